### hdl/omv_pkg.sv
package omv_pkg;

  localparam int LENGTH_BITS = 11;
  localparam int COUNT_BITS  = LENGTH_BITS + 1;
  localparam int MIC_BYTES   = 4;

  localparam logic [LENGTH_BITS-1:0] MAX_LEN_RESET = 11'd1980;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX       = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_MIC     = 12'd4;
  localparam logic [COUNT_BITS-1:0]  MIN_MSG_LEN   = 12'd4;

  localparam logic [31:0] CRC_POLY = 32'h04c1_1db7;
  localparam logic [31:0] CRC_ONES = 32'hffff_ffff;

  // Bit positions in the header flags word
  localparam int FLAG_VERIFIED   = 0;
  localparam int FLAG_STRIPPED   = 1;
  localparam int FLAG_HW_PRESENT = 2;
  localparam int FLAG_HW_VALID   = 3;
  localparam int FLAG_HW_CRCERR  = 4;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_LENGTH   = 2'd1,
    STATUS_MIC_MISMATCH = 2'd2
  } status_t;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       hw_mic_present;
    logic       hw_mic_valid;
    logic       hw_crc_error;
  } frame_t;

  // Output word
  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   out_byte_valid;
    logic                   end_of_frame;
    logic [1:0]             frame_status;
    logic [LENGTH_BITS-1:0] message_length;
    logic [4:0]             header_flags;
  } result_t;

  // Classified word passed from front to back
  typedef struct packed {
    logic [7:0]             data;
    logic                   has_byte;
    logic                   last;
    logic                   length_bad;
    logic [LENGTH_BITS-1:0] msg_length;
    logic [31:0]            mic;
    logic                   hw_present;
    logic                   hw_valid;
    logic                   hw_crc_error;
  } entry_t;

  // Fold one byte into a non-reflected CRC-32, MSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/omv_front.sv
module omv_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              frame_valid,
  input  omv_pkg::frame_t                   frame,
  output logic                              frame_stall,
  input  logic                              cfg_write,
  input  logic [omv_pkg::LENGTH_BITS-1:0]   cfg_data,
  input  logic                              q_full,
  output logic                              q_push,
  output omv_pkg::entry_t                   q_entry
);

  logic [7:0]                        delay [omv_pkg::MIC_BYTES];
  logic [omv_pkg::COUNT_BITS-1:0]    count;
  logic [omv_pkg::LENGTH_BITS-1:0]   max_len;

  logic                              accept;
  logic                              has_byte;
  logic [omv_pkg::COUNT_BITS-1:0]    count_next;
  logic [omv_pkg::COUNT_BITS-1:0]    full_len;
  logic                              length_bad;

  // Hold input while the queue has no room
  assign frame_stall = q_full;
  assign accept      = frame_valid && !q_full;
  assign has_byte    = (count >= omv_pkg::COUNT_MIC);

  // Classify the word: message byte out of the delay line, length check at frame end
  always_comb begin
    count_next = (count == omv_pkg::COUNT_MAX) ? count : count + 1'b1;
    full_len   = (count_next >= omv_pkg::COUNT_MIC) ? count_next - omv_pkg::COUNT_MIC : '0;
    length_bad = (count_next < omv_pkg::COUNT_MIC) || (full_len < omv_pkg::MIN_MSG_LEN) ||
                 (full_len > {1'b0, max_len});

    q_entry.data         = delay[0];
    q_entry.has_byte     = has_byte;
    q_entry.last         = frame.last_byte;
    q_entry.length_bad   = length_bad;
    q_entry.msg_length   = (full_len > {1'b0, omv_pkg::LEN_MAX}) ? omv_pkg::LEN_MAX :
                           full_len[omv_pkg::LENGTH_BITS-1:0];
    q_entry.mic          = {delay[1], delay[2], delay[3], frame.data_byte};
    q_entry.hw_present   = frame.hw_mic_present;
    q_entry.hw_valid     = frame.hw_mic_valid;
    q_entry.hw_crc_error = frame.hw_crc_error;
  end

  assign q_push = accept && (has_byte || frame.last_byte);

  // Advance the delay line and byte count; clear both at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      max_len <= omv_pkg::MAX_LEN_RESET;
      for (int i = 0; i < omv_pkg::MIC_BYTES; i++) begin
        delay[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        max_len <= cfg_data;
      end
      if (accept) begin
        if (frame.last_byte) begin
          count <= '0;
          for (int i = 0; i < omv_pkg::MIC_BYTES; i++) begin
            delay[i] <= '0;
          end
        end else begin
          count <= count_next;
          for (int i = 0; i < omv_pkg::MIC_BYTES - 1; i++) begin
            delay[i] <= delay[i+1];
          end
          delay[omv_pkg::MIC_BYTES-1] <= frame.data_byte;
        end
      end
    end
  end

`ifndef SYNTH
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    accept && frame.last_byte |=> count == '0)
    else $error("byte count not cleared after frame end");
`endif

endmodule

### hdl/omv_queue.sv
module omv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;

  assign full      = (fill == CNT_BITS'(DEPTH));
  assign not_empty = (fill != '0);
  assign rdata     = slots[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && full) || (pop && !not_empty) |-> 1'b0)
    else $error("queue pushed while full or popped while empty");
`endif

endmodule

### hdl/omv_back.sv
module omv_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  omv_pkg::entry_t   head,
  output logic              q_pop,
  output logic              result_valid,
  output omv_pkg::result_t  result,
  input  logic              result_stall
);

  logic [31:0]       crc;
  logic [31:0]       crc_upd;
  omv_pkg::status_t  status;
  omv_pkg::result_t  result_next;
  logic              ok;

  // Take the next word when the output register is free or being drained
  assign q_pop = q_valid && (!result_valid || !result_stall);

  // Fold the message byte into the CRC and judge the frame at its end
  always_comb begin
    crc_upd = head.has_byte ? omv_pkg::crc_byte(crc, head.data) : crc;
    if (head.length_bad) begin
      status = omv_pkg::STATUS_BAD_LENGTH;
    end else if (head.mic == (crc_upd ^ omv_pkg::CRC_ONES)) begin
      status = omv_pkg::STATUS_OK;
    end else begin
      status = omv_pkg::STATUS_MIC_MISMATCH;
    end
    ok = (status == omv_pkg::STATUS_OK);

    result_next                = '0;
    result_next.out_byte       = head.has_byte ? head.data : 8'd0;
    result_next.out_byte_valid = head.has_byte;
    result_next.end_of_frame   = head.last;
    if (head.last) begin
      result_next.frame_status                          = status;
      result_next.message_length                        = head.msg_length;
      result_next.header_flags[omv_pkg::FLAG_VERIFIED]   = ok;
      result_next.header_flags[omv_pkg::FLAG_STRIPPED]   = ok;
      result_next.header_flags[omv_pkg::FLAG_HW_PRESENT] = head.hw_present;
      result_next.header_flags[omv_pkg::FLAG_HW_VALID]   = head.hw_valid;
      result_next.header_flags[omv_pkg::FLAG_HW_CRCERR]  = head.hw_crc_error;
    end
  end

  // Load the output register; restart the CRC after each frame
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      crc          <= omv_pkg::CRC_ONES;
    end else if (q_pop) begin
      result_valid <= 1'b1;
      crc          <= head.last ? omv_pkg::CRC_ONES : crc_upd;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    q_pop && head.last |=> crc == omv_pkg::CRC_ONES)
    else $error("CRC not restarted after frame end");

  a_mid_frame_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.end_of_frame |->
      result.frame_status == omv_pkg::STATUS_OK && result.header_flags == 5'd0 &&
      result.message_length == '0 && result.out_byte_valid)
    else $error("mid-frame word carries end-of-frame fields");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> result_valid)
    else $error("popped word did not reach the output register");
`endif

endmodule

### hdl/omci_mic_verify_strip.sv
// OMCI MIC check and strip. Frame bytes enter on the frame channel one per clock
// unless stalled, the last marked; the four-byte MIC trailer is held back in a
// delay line and never appears on the result channel. Each message byte comes out
// as one result word, and the last input byte always yields a word with end_of_frame
// set, carrying the status (ok, bad length, MIC mismatch), the saturated message
// length and the header flags. The block sustains one byte per clock without output
// stall: the front stage updates the delay line and count, and the back stage folds
// one byte into the CRC-32 per cycle. Each word passes through the queue and the
// output register. Input is stalled only when the QUEUE_DEPTH-entry queue between the
// two stages fills, which happens only under output stall. Write max_message_length
// through cfg_write/cfg_data only while no frame is in flight.
module omci_mic_verify_strip #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  input  omv_pkg::frame_t                  frame,
  output logic                             frame_stall,
  output logic                             result_valid,
  output omv_pkg::result_t                 result,
  input  logic                             result_stall,
  input  logic                             cfg_write,
  input  logic [omv_pkg::LENGTH_BITS-1:0]  cfg_data
);

  localparam int ENTRY_BITS = $bits(omv_pkg::entry_t);

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  omv_pkg::entry_t       q_entry;
  logic [ENTRY_BITS-1:0] q_rdata;
  omv_pkg::entry_t       head;

  assign head = omv_pkg::entry_t'(q_rdata);

  omv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame       (frame),
    .frame_stall (frame_stall),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  omv_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  omv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule

### sim/tb_omci_mic_verify_strip.sv
`timescale 1ns / 1ps

module tb_omci_mic_verify_strip;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int BYTES_PER_PHASE = 170;
  localparam int SHORT_MSG_TOP   = 48;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            frame_valid  = 1'b0;
  omv_pkg::frame_t                 frame        = '0;
  logic                            frame_stall;
  logic                            result_valid;
  omv_pkg::result_t                result;
  logic                            result_stall = 1'b0;
  logic                            cfg_write    = 1'b0;
  logic [omv_pkg::LENGTH_BITS-1:0] cfg_data     = '0;

  // Frame bytes waiting to be driven, and result words still to arrive
  omv_pkg::frame_t  rx_bytes[$];
  omv_pkg::result_t predicted_words[$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int cap_now        = omv_pkg::MAX_LEN_RESET;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int frames_queued  = 0;
  int bytes_queued   = 0;
  int words_checked  = 0;
  int ends_checked   = 0;

  // Predictor state
  logic [7:0]                      line_bytes[0:3];
  logic [31:0]                     crc_acc;
  logic [omv_pkg::COUNT_BITS-1:0]  frame_count;
  logic [omv_pkg::LENGTH_BITS-1:0] length_cap;

  omci_mic_verify_strip u_dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame        (frame),
    .frame_stall  (frame_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // Non-reflected CRC-32, one data bit at a time, MSB first
  function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      if (r[31] ^ b[i]) begin
        r = {r[30:0], 1'b0} ^ omv_pkg::CRC_POLY;
      end else begin
        r = {r[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Advance the predictor by one accepted byte and queue the word it causes
  task automatic strip_and_check(input omv_pkg::frame_t f);
    omv_pkg::result_t               w;
    logic                           emit;
    logic [omv_pkg::COUNT_BITS-1:0] full;
    logic [31:0]                    mic;
    w    = '0;
    emit = (frame_count >= omv_pkg::COUNT_MIC);
    if (emit) begin
      w.out_byte       = line_bytes[0];
      w.out_byte_valid = 1'b1;
      crc_acc          = crc32_update(crc_acc, line_bytes[0]);
    end
    line_bytes[0] = line_bytes[1];
    line_bytes[1] = line_bytes[2];
    line_bytes[2] = line_bytes[3];
    line_bytes[3] = f.data_byte;
    if (frame_count != omv_pkg::COUNT_MAX) frame_count = frame_count + 1'b1;
    if (f.last_byte) begin
      full = (frame_count >= omv_pkg::COUNT_MIC) ? frame_count - omv_pkg::COUNT_MIC : '0;
      w.end_of_frame   = 1'b1;
      w.message_length = (full > {1'b0, omv_pkg::LEN_MAX}) ? omv_pkg::LEN_MAX :
                         full[omv_pkg::LENGTH_BITS-1:0];
      if (full < omv_pkg::MIN_MSG_LEN || full > {1'b0, length_cap}) begin
        w.frame_status = omv_pkg::STATUS_BAD_LENGTH;
      end else begin
        mic = {line_bytes[0], line_bytes[1], line_bytes[2], line_bytes[3]};
        w.frame_status = (mic == ~crc_acc) ? omv_pkg::STATUS_OK :
                                             omv_pkg::STATUS_MIC_MISMATCH;
      end
      if (w.frame_status == omv_pkg::STATUS_OK) begin
        w.header_flags[omv_pkg::FLAG_VERIFIED] = 1'b1;
        w.header_flags[omv_pkg::FLAG_STRIPPED] = 1'b1;
      end
      w.header_flags[omv_pkg::FLAG_HW_PRESENT] = f.hw_mic_present;
      w.header_flags[omv_pkg::FLAG_HW_VALID]   = f.hw_mic_valid;
      w.header_flags[omv_pkg::FLAG_HW_CRCERR]  = f.hw_crc_error;
      line_bytes  = '{default: 8'h00};
      crc_acc     = omv_pkg::CRC_ONES;
      frame_count = '0;
    end
    if (emit || f.last_byte) predicted_words.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input omv_pkg::result_t want,
                                 input omv_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected byte=%02h v=%0d eof=%0d st=%0d len=%0d flags=%02h",
               $realtime, what, want.out_byte, want.out_byte_valid, want.end_of_frame,
               want.frame_status, want.message_length, want.header_flags);
      $display("%0t %s:      got byte=%02h v=%0d eof=%0d st=%0d len=%0d flags=%02h",
               $realtime, what, got.out_byte, got.out_byte_valid, got.end_of_frame,
               got.frame_status, got.message_length, got.header_flags);
    end
  endtask

  // Compare one received word against the oldest prediction
  task automatic check_word(input omv_pkg::result_t got);
    omv_pkg::result_t want;
    if (predicted_words.size() == 0) begin
      report_mismatch("unexpected word", '0, got);
    end else begin
      want = predicted_words.pop_front();
      words_checked++;
      if (want.end_of_frame) ends_checked++;
      if (got.out_byte !== want.out_byte || got.out_byte_valid !== want.out_byte_valid ||
          got.end_of_frame !== want.end_of_frame || got.frame_status !== want.frame_status ||
          got.message_length !== want.message_length ||
          got.header_flags !== want.header_flags) begin
        report_mismatch("word mismatch", want, got);
      end
    end
  endtask

  // Track config writes, accepted bytes and accepted words
  always @(posedge clk) begin
    if (rst) begin
      line_bytes  = '{default: 8'h00};
      crc_acc     = omv_pkg::CRC_ONES;
      frame_count = '0;
      length_cap  = omv_pkg::MAX_LEN_RESET;
    end else begin
      if (cfg_write) length_cap = cfg_data;
      if (frame_valid && !frame_stall) strip_and_check(frame);
      if (result_valid && !result_stall) check_word(result);
    end
  end

  // Drive the next byte once the current one is taken, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (!frame_valid || !frame_stall) begin
      if (rx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        frame       <= rx_bytes.pop_front();
        frame_valid <= 1'b1;
      end else begin
        frame_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    omv_pkg::frame_t f;
    f.data_byte = b;
    f.last_byte = last;
    {f.hw_mic_present, f.hw_mic_valid, f.hw_crc_error} = 3'($urandom);
    rx_bytes.push_back(f);
    bytes_queued++;
  endtask

  // Queue a message followed by its MIC, optionally with one bit flipped
  task automatic add_frame(input int msg_len, input bit corrupt, input fill_t fill);
    logic [31:0] acc;
    logic [7:0]  b;
    logic [31:0] mic;
    acc = omv_pkg::CRC_ONES;
    for (int i = 0; i < msg_len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hff;
        default:   b = 8'($urandom);
      endcase
      acc = crc32_update(acc, b);
      push_byte(b, 1'b0);
    end
    mic = ~acc;
    if (corrupt) mic = mic ^ (32'd1 << $urandom_range(0, 31));
    for (int k = 3; k >= 0; k--) push_byte(mic[8*k +: 8], k == 0);
    frames_queued++;
  endtask

  // Queue a frame of random bytes with no valid trailer
  task automatic add_raw(input int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), i == n - 1);
    frames_queued++;
  endtask

  task automatic add_random_frames(input int budget);
    int stop;
    int r;
    stop = bytes_queued + budget;
    while (bytes_queued < stop) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        add_frame($urandom_range(4, cap_now < SHORT_MSG_TOP ? cap_now : SHORT_MSG_TOP),
                  $urandom_range(0, 99) < 12, FILL_RANDOM);
      end else if (r < 82 && cap_now <= 100) begin
        add_frame(cap_now - 1 + $urandom_range(0, 2), 1'b0, FILL_RANDOM);
      end else if (r < 92) begin
        add_raw($urandom_range(1, 7));
      end else begin
        add_frame($urandom_range(0, 60), $urandom_range(0, 1) == 1, FILL_RANDOM);
      end
    end
  endtask

  // Wait until every byte is taken and every word has arrived
  task automatic drain_to_idle();
    while (rx_bytes.size() != 0 || frame_valid || predicted_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_max_length(input int value);
    drain_to_idle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= omv_pkg::LENGTH_BITS'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    cap_now = value;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: short frames, tiny messages, good and bad MIC, flat payloads
    add_raw(1);
    add_raw(2);
    add_raw(3);
    add_frame(0, 1'b0, FILL_RANDOM);
    add_frame(1, 1'b0, FILL_RANDOM);
    add_frame(3, 1'b0, FILL_RANDOM);
    add_frame(4, 1'b0, FILL_RANDOM);
    add_frame(4, 1'b1, FILL_RANDOM);
    add_frame(10, 1'b0, FILL_ZERO);
    add_frame(10, 1'b1, FILL_ONES);
    add_frame(20, 1'b0, FILL_ONES);

    // Smallest cap, sender gaps
    set_max_length(4);
    send_idle_pct = 60;
    add_frame(4, 1'b0, FILL_RANDOM);
    add_frame(5, 1'b0, FILL_RANDOM);
    add_random_frames(BYTES_PER_PHASE);

    // Largest cap, output stalls and a longer message
    set_max_length(2047);
    send_idle_pct = 0;
    stall_pct     = 60;
    add_frame(120, 1'b0, FILL_RANDOM);
    add_random_frames(BYTES_PER_PHASE);

    // Random cap, gaps and stalls together
    set_max_length($urandom_range(5, 100));
    send_idle_pct = 22;
    stall_pct     = 22;
    add_random_frames(BYTES_PER_PHASE);

    // Mid cap, full rate
    set_max_length(20);
    send_idle_pct = 0;
    stall_pct     = 0;
    add_frame(20, 1'b0, FILL_RANDOM);
    add_frame(21, 1'b0, FILL_RANDOM);
    add_random_frames(BYTES_PER_PHASE);

    drain_to_idle();
    if (predicted_words.size() != 0) begin
      $display("%0d predicted words never arrived", predicted_words.size());
      mismatch_count += predicted_words.size();
    end
    $display("Sent %0d frames (%0d bytes) under five length caps and four idle patterns;",
             frames_queued, bytes_queued);
    $display("checked %0d result words including %0d frame ends, %0d mismatches.",
             words_checked, ends_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### omci_mic_verify_strip.f
hdl/omv_pkg.sv
hdl/omv_front.sv
hdl/omv_queue.sv
hdl/omv_back.sv
hdl/omci_mic_verify_strip.sv
sim/tb_omci_mic_verify_strip.sv
